// File: rtl/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_ACK  = 2'd1,
		OP_TICK = 2'd2,
		OP_RSVD = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_SEND   = 3'd0,
		KIND_RETX   = 3'd1,
		KIND_REFUSE = 3'd2,
		KIND_ACK    = 3'd3,
		KIND_IDLE   = 3'd4
	} kind_t;

	// configuration register indexes
	localparam logic CFG_WINDOW_LIMIT  = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS = 1'b1;

	localparam logic [4:0]  WINDOW_LIMIT_RST  = 5'd8;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd4;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_RETX  = 4'b0100,
		S_SCAN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic emit_send;
		logic emit_refuse;
		logic emit_idle;
		logic retx_start;
		logic emit_retx;
		logic scan_step;
		logic emit_ack;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic timed_out;
		logic has_room;
		logic scan_more;
		logic retx_last;
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/gbn_ctrl.sv
`timescale 1ns / 1ps

module gbn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  gbn_pkg::op_t        in_op,
	output logic                in_ready,
	input  gbn_pkg::dp_status_t st,
	output gbn_pkg::dp_cmd_t    cmd
);
	import gbn_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					// unused code is taken and dropped
					if (in_op != OP_RSVD) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				unique case (st.op) inside
					OP_ACK: begin
						state_d = S_SCAN;
					end
					OP_SEND, OP_TICK: begin
						if (st.timed_out) begin
							cmd.retx_start = 1'b1;
							state_d        = S_RETX;
						end else if (st.out_free) begin
							if (st.op == OP_TICK) begin
								cmd.emit_idle = 1'b1;
							end else if (st.has_room) begin
								cmd.emit_send = 1'b1;
							end else begin
								cmd.emit_refuse = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_RETX: begin
				if (st.out_free) begin
					cmd.emit_retx = 1'b1;
					if (st.retx_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_SCAN: begin
				if (st.scan_more) begin
					cmd.scan_step = 1'b1;
				end else if (st.out_free) begin
					cmd.emit_ack = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/gbn_dpath.sv
`timescale 1ns / 1ps

module gbn_dpath #(
	parameter int WINDOW_MAX = 16,
	parameter int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gbn_pkg::dp_cmd_t    cmd,
	output gbn_pkg::dp_status_t st,
	input  gbn_pkg::op_t        in_op,
	input  logic [31:0]         in_ack,
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          out_kind,
	output logic [31:0]         out_seq,
	output logic [CNT_W-1:0]    out_freed,
	output logic [CNT_W-1:0]    out_outstanding,
	output logic                out_last
);
	import gbn_pkg::*;

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	logic [4:0]       window_limit_q;
	logic [15:0]      timeout_ticks_q;
	logic [31:0]      base_q, next_q, now_q, ack_q;
	logic [CNT_W-1:0] pending_q, freed_q, idx_q;
	logic [IDX_W-1:0] head_q;
	op_t              op_q;

	logic [31:0]      mem [WINDOW_MAX];
	logic [31:0]      rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;

	logic             load;
	logic [31:0]      age;
	logic [SUM_W-1:0] idx_next;

	logic [2:0]       res_kind;
	logic [31:0]      res_seq;
	logic [CNT_W-1:0] res_freed;
	logic [CNT_W-1:0] res_outst;
	logic             res_last;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(h) + SUM_W'(off);
		if (s >= SUM_W'(WINDOW_MAX)) begin
			s = s - SUM_W'(WINDOW_MAX);
		end
		return s[IDX_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_limit_q  <= WINDOW_LIMIT_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_WINDOW_LIMIT) begin
				window_limit_q <= cfg_data[4:0];
			end else begin
				timeout_ticks_q <= cfg_data;
			end
		end
	end

	// send-time store, read at the oldest slot every cycle
	assign mem_we    = cmd.emit_send | cmd.emit_retx;
	assign mem_waddr = cmd.emit_retx ? ring_add(head_q, idx_q) : ring_add(head_q, pending_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= now_q;
		end
		rd_q <= mem[head_q];
	end

	assign age      = now_q - rd_q;
	assign idx_next = SUM_W'(idx_q) + SUM_W'(1);

	assign st.op        = op_q;
	assign st.timed_out = (pending_q != '0) && (age >= {16'd0, timeout_ticks_q});
	assign st.has_room  = (pending_q < CNT_W'(WINDOW_MAX)) &&
	                      (CMP_W'(pending_q) < CMP_W'(window_limit_q));
	assign st.scan_more = (freed_q < pending_q) && ((base_q + 32'(freed_q)) <= ack_q);
	assign st.retx_last = (idx_next == SUM_W'(pending_q));
	assign st.out_free  = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			next_q    <= '0;
			now_q     <= '0;
			pending_q <= '0;
			head_q    <= '0;
			freed_q   <= '0;
			idx_q     <= '0;
			op_q      <= OP_RSVD;
			ack_q     <= '0;
		end else begin
			if (cmd.accept) begin
				op_q    <= in_op;
				ack_q   <= in_ack;
				freed_q <= '0;
				if (in_op == OP_TICK) begin
					now_q <= now_q + 32'd1;
				end
			end
			if (cmd.emit_send) begin
				pending_q <= pending_q + CNT_W'(1);
				next_q    <= next_q + 32'd1;
			end
			if (cmd.retx_start) begin
				idx_q <= '0;
			end
			if (cmd.emit_retx) begin
				idx_q <= idx_next[CNT_W-1:0];
			end
			if (cmd.scan_step) begin
				freed_q <= freed_q + CNT_W'(1);
			end
			if (cmd.emit_ack) begin
				base_q    <= base_q + 32'(freed_q);
				head_q    <= ring_add(head_q, freed_q);
				pending_q <= pending_q - freed_q;
			end
		end
	end

	// result register
	assign load = cmd.emit_send | cmd.emit_refuse | cmd.emit_idle | cmd.emit_retx |
	              cmd.emit_ack;

	always_comb begin
		res_kind  = KIND_ACK;
		res_seq   = '0;
		res_freed = '0;
		res_outst = pending_q;
		res_last  = 1'b1;
		if (cmd.emit_send) begin
			res_kind  = KIND_SEND;
			res_seq   = next_q;
			res_outst = pending_q + CNT_W'(1);
		end else if (cmd.emit_refuse) begin
			res_kind = KIND_REFUSE;
		end else if (cmd.emit_idle) begin
			res_kind = KIND_IDLE;
		end else if (cmd.emit_retx) begin
			res_kind = KIND_RETX;
			res_seq  = base_q + 32'(idx_q);
			res_last = st.retx_last;
		end else begin
			res_freed = freed_q;
			res_outst = pending_q - freed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind        <= res_kind;
			out_seq         <= res_seq;
			out_freed       <= res_freed;
			out_outstanding <= res_outst;
			out_last        <= res_last;
		end
	end

endmodule

// File: rtl/go_back_n_sender_window.sv
// Send request or tick without timeout: op registered, decided in S_CHECK once the output is free,
// result then registered; no new item is taken until the controller is back in S_IDLE.
// Ack: the scan tests one window entry per cycle, then the ack result waits for a free output.
// Go-back retransmit: one result per cycle per outstanding entry while the output is free.
// Reset (arst_n low) clears sequence, count, time and ring pointers, window_limit = 8,
// timeout_ticks = 4; the send-time store is not cleared and needs no sweep.
`timescale 1ns / 1ps

module go_back_n_sender_window #(
	parameter int WINDOW_MAX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           operation,
	input  logic [31:0]                          ack_seq,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0]                           result_kind,
	output logic [31:0]                          seq_out,
	output logic [$clog2(WINDOW_MAX + 1)-1:0]    freed_count,
	output logic [$clog2(WINDOW_MAX + 1)-1:0]    outstanding,
	output logic                                 last_of_run,
	input  logic                                 cfg_wr_en,
	input  logic                                 cfg_index,
	input  logic [15:0]                          cfg_data
);
	import gbn_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	op_t        in_op;
	dp_cmd_t    cmd;
	dp_status_t st;

	assign in_op = op_t'(operation);

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_op),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	gbn_dpath #(
		.WINDOW_MAX (WINDOW_MAX),
		.CNT_W      (CNT_W)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.in_op           (in_op),
		.in_ack          (ack_seq),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_kind        (result_kind),
		.out_seq         (seq_out),
		.out_freed       (freed_count),
		.out_outstanding (outstanding),
		.out_last        (last_of_run)
	);

endmodule

// File: tb/sv/gbn_window_checker.sv
`timescale 1ns / 1ps

module gbn_window_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] ack_seq,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  result_kind,
	input  logic [31:0] seq_out,
	input  logic [4:0]  freed_count,
	input  logic [4:0]  outstanding,
	input  logic        last_of_run,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          awaited,
	output logic [31:0] next_hint
);
	import gbn_pkg::*;

	localparam logic [4:0] RING_SLOTS = 5'd16;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] seq;
		logic [4:0]  freed;
		logic [4:0]  outst;
		logic        last;
	} window_result_t;

	// predicted results waiting for their transfer out
	window_result_t exp_fifo [64];
	logic [5:0]     exp_wr;
	logic [5:0]     exp_rd;
	int             exp_fill;

	logic [4:0]  limit_q;
	logic [15:0] timeout_q;
	logic [31:0] base_q;
	logic [31:0] next_q;
	logic [31:0] now_q;
	logic [4:0]  count_q;
	logic [3:0]  head_q;
	logic [31:0] send_time_q [16];

	task automatic record_result(window_result_t r);
		exp_fifo[exp_wr] = r;
		exp_wr = exp_wr + 6'd1;
		exp_fill++;
	endtask

	function automatic logic oldest_expired();
		return count_q != 5'd0 && (now_q - send_time_q[head_q]) >= {16'd0, timeout_q};
	endfunction

	// go back: every outstanding entry goes out again with a fresh send time
	task automatic go_back();
		for (int i = 0; i < count_q; i++) begin
			send_time_q[head_q + 4'(i)] = now_q;
			record_result('{KIND_RETX, base_q + 32'(i), 5'd0, count_q,
				i == count_q - 1});
		end
	endtask

	task automatic window_step(op_t op, logic [31:0] ack);
		logic [4:0] cap;
		logic [4:0] freed;
		case (op)
			OP_SEND: begin
				cap = (limit_q > RING_SLOTS) ? RING_SLOTS : limit_q;
				if (oldest_expired()) begin
					go_back();
				end else if (count_q < cap) begin
					send_time_q[head_q + count_q[3:0]] = now_q;
					count_q = count_q + 5'd1;
					record_result('{KIND_SEND, next_q, 5'd0, count_q, 1'b1});
					next_q = next_q + 32'd1;
				end else begin
					record_result('{KIND_REFUSE, 32'd0, 5'd0, count_q, 1'b1});
				end
			end
			OP_ACK: begin
				freed = 5'd0;
				// plain unsigned compare, no wraparound
				while (freed < count_q && (base_q + 32'(freed)) <= ack)
					freed = freed + 5'd1;
				base_q = base_q + 32'(freed);
				head_q = head_q + freed[3:0];
				count_q = count_q - freed;
				record_result('{KIND_ACK, 32'd0, freed, count_q, 1'b1});
			end
			OP_TICK: begin
				now_q = now_q + 32'd1;
				if (oldest_expired())
					go_back();
				else
					record_result('{KIND_IDLE, 32'd0, 5'd0, count_q, 1'b1});
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_result_t exp_r;
		window_result_t got_r;
		if (!arst_n) begin
			limit_q = WINDOW_LIMIT_RST;
			timeout_q = TIMEOUT_TICKS_RST;
			base_q = '0;
			next_q = '0;
			now_q = '0;
			count_q = '0;
			head_q = '0;
			exp_wr = '0;
			exp_rd = '0;
			exp_fill = 0;
			mismatch_count = 0;
			awaited <= 0;
			next_hint <= '0;
		end else begin
			if (out_valid && out_ready) begin
				got_r = '{kind_t'(result_kind), seq_out, freed_count, outstanding, last_of_run};
				if (exp_fill == 0) begin
					if (mismatch_count < 10)
						$display({"unexpected result: kind %0d seq %0d freed %0d",
							" outstanding %0d last %0b"},
							got_r.kind, got_r.seq, got_r.freed, got_r.outst, got_r.last);
					mismatch_count++;
				end else begin
					exp_r = exp_fifo[exp_rd];
					exp_rd = exp_rd + 6'd1;
					exp_fill--;
					if (got_r.kind !== exp_r.kind || got_r.seq !== exp_r.seq ||
							got_r.freed !== exp_r.freed || got_r.outst !== exp_r.outst ||
							got_r.last !== exp_r.last) begin
						if (mismatch_count < 10) begin
							$display({"mismatch: expected kind %0d seq %0d freed %0d",
								" outstanding %0d last %0b"},
								exp_r.kind, exp_r.seq, exp_r.freed, exp_r.outst, exp_r.last);
							$display({"          got      kind %0d seq %0d freed %0d",
								" outstanding %0d last %0b"},
								got_r.kind, got_r.seq, got_r.freed, got_r.outst, got_r.last);
						end
						mismatch_count++;
					end
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == CFG_WINDOW_LIMIT)
					limit_q = cfg_data[4:0];
				else
					timeout_q = cfg_data;
			end
			if (in_valid && in_ready)
				window_step(op_t'(operation), ack_seq);
			awaited <= exp_fill;
			next_hint <= next_q;
		end
	end

endmodule

// File: tb/sv/tb_go_back_n_sender_window.sv
`timescale 1ns / 1ps

module tb_go_back_n_sender_window;
	import gbn_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [31:0] ack_seq;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  result_kind;
	logic [31:0] seq_out;
	logic [4:0]  freed_count;
	logic [4:0]  outstanding;
	logic        last_of_run;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int          mismatch_count;
	int          awaited;
	logic [31:0] next_hint;
	bit          hold_req;

	go_back_n_sender_window DUT (.*);

	gbn_window_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic offer(op_t op, logic [31:0] ack);
		in_valid <= 1'b1;
		operation <= op;
		ack_seq <= ack;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain: nothing in flight, then let an unanswered scan or ignored op finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver: runs of random stall patterns, plus one long hold-off on request
	initial begin
		int mode;
		int span;
		bit hold_done;
		hold_done = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(1, 30);
			repeat (span) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int          issued;
		int          burst_left;
		int          gap;
		int          pick;
		op_t         op;
		logic [31:0] ack;
		logic [4:0]  lim;
		logic [15:0] tmo;

		hold_req = 1'b0;
		burst_left = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_SEND;
		ack_seq <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_WINDOW_LIMIT;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings: limit 8, timeout 4
		offer(OP_RSVD, 32'hFFFF_FFFF);
		offer(OP_ACK, 32'd0);
		offer(OP_TICK, 32'd0);
		repeat (9) offer(OP_SEND, 32'd0);
		offer(OP_ACK, 32'd2);
		offer(OP_ACK, 32'd1);
		repeat (4) offer(OP_TICK, 32'd0);
		offer(OP_SEND, 32'd0);
		offer(OP_ACK, 32'hFFFF_FFFF);
		offer(OP_SEND, 32'd0);
		offer(OP_ACK, 32'h8000_0000);
		offer(OP_SEND, 32'd0);
		settle();

		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				case (p)
					1: begin lim = 5'd1;  tmo = 16'd1;     end
					2: begin lim = 5'd16; tmo = 16'd8;     end
					3: begin lim = 5'd0;  tmo = 16'd3;     end
					4: begin lim = 5'd31; tmo = 16'd2;     end
					5: begin lim = 5'd5;  tmo = 16'd0;     end
					6: begin lim = 5'd3;  tmo = 16'hFFFF;  end
					default: begin lim = 5'd16; tmo = 16'd6; end
				endcase
				cfg_wr_en <= 1'b1;
				cfg_index <= CFG_WINDOW_LIMIT;
				cfg_data <= {11'd0, lim};
				@(posedge clk);
				cfg_index <= CFG_TIMEOUT_TICKS;
				cfg_data <= tmo;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
			end
			// phase 2 runs gapless against a long receiver hold-off
			if (p == 2)
				hold_req = 1'b1;
			issued = 0;
			while (issued < 35) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					op = OP_SEND;
				else if (pick < 65)
					op = OP_ACK;
				else if (pick < 95)
					op = OP_TICK;
				else
					op = OP_RSVD;
				case ($urandom_range(0, 9))
					0: ack = $urandom();
					1: ack = 32'd0;
					2: ack = 32'hFFFF_FFFF;
					default: ack = next_hint - $urandom_range(0, 6);
				endcase
				offer(op, ack);
				if (op != OP_RSVD)
					issued++;
				if (p != 2) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						if (gap > 0) begin
							in_valid <= 1'b0;
							repeat (gap) @(posedge clk);
						end
					end else begin
						burst_left--;
					end
				end
			end
			settle();
		end

		if (mismatch_count == 0 && awaited == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: go_back_n_sender_window.f
rtl/gbn_pkg.sv
rtl/gbn_ctrl.sv
rtl/gbn_dpath.sv
rtl/go_back_n_sender_window.sv
tb/sv/gbn_window_checker.sv
tb/sv/tb_go_back_n_sender_window.sv
